FILE: sv/assert_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, off while rst is high.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication, checked on every rising edge of clk.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/utcld_pkg.sv
// Types, constants and helper functions for the UTC to local date converter.
package utcld_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int CODE_W  = 8;
  localparam int FLAG_W  = 3;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  localparam logic [CODE_W-1:0] OFFSET_BIAS     = 8'd48;
  localparam logic [CODE_W-1:0] OFFSET_CODE_MAX = 8'd104;
  localparam int               QUARTER_MIN     = 15;
  localparam int               MIN_PER_DAY     = 1440;
  localparam int               TOD_W           = 12;
  // Shifted minute count below LOW_LIMIT is the previous day, at or above HIGH_LIMIT the next
  localparam logic [TOD_W-1:0] LOW_LIMIT  = TOD_W'(48 * QUARTER_MIN);
  localparam logic [TOD_W-1:0] HIGH_LIMIT = TOD_W'(MIN_PER_DAY + 48 * QUARTER_MIN);

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] MONTH_LEN [0:11] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // 25 * INV25 == 1 mod 2^14: y is a multiple of 25 iff y * INV25 (mod 2^14) <= DIV25_MAX
  localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

  // floor(r / 100) == (r * RECIP100) >> RECIP100_SH for r below 10000
  localparam logic [YEAR_W-1:0] YEAR_10K    = 14'd10000;
  localparam logic [12:0]       RECIP100    = 13'd5243;
  localparam int                RECIP100_SH = 19;
  localparam int                PROD100_W   = 26;

  typedef struct packed {
    logic                 ok;
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
  } date_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] n;
    n = 5'd31;
    if (m >= MONTH_JAN && m <= MONTH_DEC) n = MONTH_LEN[m - MONTH_JAN];
    if (m == MONTH_FEB && leap) n = n + 5'd1;
    return n;
  endfunction

  // Two BCD digits of a value below 100; tens by reciprocal 205 / 2^11
  function automatic logic [7:0] bcd2(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rest;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    rest = v - 7'(tens) * 7'd10;
    return {tens, rest[3:0]};
  endfunction

endpackage

FILE: sv/utcld_roll.sv
// Offset the UTC time of day and roll the Gregorian date by one day either way.
module utcld_roll
  import utcld_pkg::*;
(
  input  logic [FLAG_W-1:0]  flags,
  input  logic [YEAR_W-1:0]  year,
  input  logic [MONTH_W-1:0] month,
  input  logic [DAY_W-1:0]   day,
  input  logic [HOUR_W-1:0]  hour,
  input  logic [MIN_W-1:0]   minute,
  input  logic [CODE_W-1:0]  offset_code,
  output date_t              date
);

  logic [6:0]         code;
  logic [TOD_W-1:0]   tod;
  logic               dn, up;
  logic [5:0]         dpos;
  logic [5:0]         d_base;
  logic [YEAR_W-1:0]  lowprod;
  logic               div25, leap;
  logic [MONTH_W-1:0] month_prev, month_next;
  logic [DAY_W-1:0]   md_prev, md_cur;
  logic               valid;
  date_t              rolled;

  always_comb begin
    code = (offset_code > OFFSET_CODE_MAX) ? OFFSET_CODE_MAX[6:0] : offset_code[6:0];
    tod  = TOD_W'(hour) * TOD_W'(60) + TOD_W'(minute) + TOD_W'(code) * TOD_W'(QUARTER_MIN);
    dn   = tod < LOW_LIMIT;
    up   = tod >= HIGH_LIMIT;
    // day + 1 + shift, so the value stays unsigned
    dpos   = 6'(day) + 6'd1 + 6'(up) - 6'(dn);
    d_base = dpos - 6'd1;

    // leap: multiple of 4 but not 100, or multiple of 400 (16 and 25)
    lowprod = YEAR_W'(year * INV25);
    div25   = lowprod <= DIV25_MAX;
    leap    = ((year[1:0] == 2'd0) && !div25) || ((year[3:0] == 4'd0) && div25);

    month_prev = (month == MONTH_JAN) ? MONTH_DEC : month - 4'd1;
    month_next = (month == MONTH_DEC) ? MONTH_JAN : month + 4'd1;
    md_prev    = month_days(month_prev, leap);
    md_cur     = month_days(month, leap);

    rolled.ok = 1'b1;
    priority if (dpos < 6'd2) begin
      rolled.year  = (month == MONTH_JAN) ? year - 14'd1 : year;
      rolled.month = month_prev;
      rolled.day   = DAY_W'(dpos + 6'(md_prev) - 6'd1);
    end else if (d_base > 6'(md_cur)) begin
      rolled.year  = (month == MONTH_DEC) ? year + 14'd1 : year;
      rolled.month = month_next;
      rolled.day   = DAY_W'(d_base - 6'(md_cur));
    end else begin
      rolled.year  = year;
      rolled.month = month;
      rolled.day   = d_base[DAY_W-1:0];
    end

    valid = (&flags) && (month >= MONTH_JAN) && (month <= MONTH_DEC);
    date  = valid ? rolled : '0;
  end

endmodule

FILE: sv/utc_to_local_date_converter.sv
// Top level of the UTC to local date converter: APB register, pipeline, output register.
//
// Use: one request on the s_ channel carries a UTC date and time plus three status
// flags in s_tuser. The block adds the quarter-hour UTC offset held in offset_code
// (APB, byte address 0, reset 48 = UTC, codes above 104 act as 104), rolls the date
// by -1, 0 or +1 day and returns one result request on the m_ channel: local date in
// binary and as BCD digits, date_valid in m_tuser. A clear flag or a month outside
// 1..12 gives date_valid low and all data zero.
// Path: an accepted request passes the input register, the date roll, the year split
// by hundreds and the BCD digits into the output register before m_tvalid rises.
// Throughput: one request per cycle while m_tready does not hold the output, set by
// the four-register pipeline; every stage has its own valid bit.
// Stalls: a stage advances when it is empty or the stage after it moves, so bubbles
// close up and new requests keep coming in while a finished result waits on m_tready.
// s_tready falls only once all four stages hold requests.
// Reset clears every valid bit and returns offset_code to 48. Write the register
// only while no request is in flight.
`include "assert_macros.svh"

module utc_to_local_date_converter
  import utcld_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input requests
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [13:0] utc_year, [17:14] utc_month, [22:18] utc_day, [27:23] utc_hour,
  // [33:28] utc_minute, [39:34] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] clock_available, [1] clock_synced, [2] read_ok
  input  logic [FLAG_W-1:0]     s_tuser,
  // result requests
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [13:0] local_year, [17:14] local_month, [22:18] local_day, [27:23] month_bcd,
  // [33:28] day_bcd, [49:34] year_bcd, [55:50] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  // [0] date_valid
  output logic                  m_tuser,
  // APB register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic REG_OFFSET = 1'b0;  // word address of offset_code

  logic [CODE_W-1:0] offset_code;

  // pipeline stages
  logic                 p0_valid, p1_valid, p2_valid;
  logic                 p0_ready, p1_ready, p2_ready, out_ready;
  logic [FLAG_W-1:0]    p0_flags;
  logic [IN_DATA_W-1:0] p0_data;
  date_t                roll_date;
  date_t                p1_date, p2_date;
  logic [6:0]           p2_hi, p2_lo;

  logic [YEAR_W-1:0]    y_mod;
  logic [PROD100_W-1:0] prod100;
  logic [6:0]           hi, lo;
  logic [7:0]           month_bcd2, day_bcd2, hi_bcd, lo_bcd;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OFFSET) ? 32'(offset_code) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_code <= OFFSET_BIAS;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_OFFSET) begin
      offset_code <= pwdata[CODE_W-1:0];
    end
  end

  // each stage takes a new request when empty or when its content moves on
  assign out_ready = !m_tvalid || m_tready;
  assign p2_ready  = !p2_valid || out_ready;
  assign p1_ready  = !p1_valid || p2_ready;
  assign p0_ready  = !p0_valid || p1_ready;
  assign s_tready  = p0_ready;

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (p0_ready) begin
      p0_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (p0_ready && s_tvalid) begin
      p0_flags <= s_tuser;
      p0_data  <= s_tdata;
    end
  end

  // stage 1: offset and date roll
  utcld_roll u_roll (
    .flags       (p0_flags),
    .year        (p0_data[13:0]),
    .month       (p0_data[17:14]),
    .day         (p0_data[22:18]),
    .hour        (p0_data[27:23]),
    .minute      (p0_data[33:28]),
    .offset_code (offset_code),
    .date        (roll_date)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (p1_ready) begin
      p1_valid <= p0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_ready && p0_valid) p1_date <= roll_date;
  end

  // stage 2: low four decimal digits of the year, split into hundreds and rest
  always_comb begin
    y_mod   = (p1_date.year >= YEAR_10K) ? p1_date.year - YEAR_10K : p1_date.year;
    prod100 = PROD100_W'(y_mod) * PROD100_W'(RECIP100);
    hi      = prod100[PROD100_W-1:RECIP100_SH];
    lo      = 7'(y_mod - YEAR_W'(hi) * 14'd100);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (p2_ready) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_ready && p1_valid) begin
      p2_date <= p1_date;
      p2_hi   <= hi;
      p2_lo   <= lo;
    end
  end

  // stage 3: BCD digits into the output register
  always_comb begin
    month_bcd2 = bcd2(7'(p2_date.month));
    day_bcd2   = bcd2(7'(p2_date.day));
    hi_bcd     = bcd2(p2_hi);
    lo_bcd     = bcd2(p2_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && p2_valid) begin
      m_tuser <= p2_date.ok;
      m_tdata <= {6'd0, hi_bcd, lo_bcd, day_bcd2[5:0], month_bcd2[4:0],
                  p2_date.day, p2_date.month, p2_date.year};
    end
  end

  // checks
  `ASSERT_IMP(a_month_range, m_tvalid && m_tuser,
              m_tdata[17:14] >= MONTH_JAN && m_tdata[17:14] <= MONTH_DEC,
              "valid result with month outside 1..12")
  `ASSERT_IMP(a_day_range, m_tvalid && m_tuser, m_tdata[22:18] != 5'd0,
              "valid result with day zero")
  `ASSERT_IMP(a_invalid_zero, m_tvalid && !m_tuser, m_tdata == '0,
              "invalid result carries non-zero data")
  `ASSERT_IMP(a_month_tens, m_tvalid, (m_tdata[17:14] >= 4'd10) == m_tdata[27],
              "month BCD tens digit disagrees with binary month")
  `ASSERT_PROP(a_stage2_hold, p2_valid && !out_ready |=> p2_valid && $stable(p2_date),
               "stage 2 request lost or changed while stalled")

endmodule
